@@ rtl/core/bba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

	localparam int unsigned DEF_MAX_BLOCKS  = 256;
	localparam int unsigned DEF_BLOCK_BYTES = 32;
	localparam int unsigned CNT_W           = 11;
	localparam int unsigned RB_W            = 23;
	localparam int unsigned NEED_W          = 17;
	localparam int unsigned CFG_W           = 9;
	localparam logic [CFG_W-1:0]  MB_RESET     = 9'd256;
	localparam logic [NEED_W-1:0] HEADER_BYTES = 17'd4;
	localparam logic [15:0]       REF_MAX      = 16'hFFFF;

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RETAIN  = 2'd1;
	localparam logic [1:0] FUNC_RELEASE = 2'd2;
	localparam logic [1:0] FUNC_QUERY   = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_OOM      = 2'd1;
	localparam logic [1:0] ST_RELEASED = 2'd2;

	typedef enum logic {MODE_ALLOC, MODE_REL} mode_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] alloc_size;
		logic [7:0]  handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  alloc_handle;
		logic [13:0] free_bytes;
	} rsp_t;

	typedef struct packed {
		mode_t             mode;
		logic              init;
		logic              mark;
		logic [CNT_W-1:0]  n;
		logic [CNT_W-1:0]  lo;
		logic [CNT_W-1:0]  hi;
		logic [NEED_W-1:0] need_bytes;
	} bcast_t;

	typedef struct packed {
		logic             valid;
		logic             done;
		logic [CNT_W-1:0] run;
		logic [RB_W-1:0]  runb;
		logic [CNT_W-1:0] first;
	} tok_t;

endpackage

@@ rtl/core/bba_cell.sv @@
// One pool block: free bit plus the scan/release beat passing through it.
module bba_cell #(
	parameter int unsigned IDX         = 0,
	parameter int unsigned BLOCK_BYTES = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bba_pkg::bcast_t bc,
	input  bba_pkg::tok_t   tok_in,
	output bba_pkg::tok_t   tok_out
);
	import bba_pkg::*;

	localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);

	logic             free_q;
	tok_t             tok_q;
	tok_t             nxt;
	logic             active;
	logic             in_rng;
	logic [CNT_W-1:0] run_inc;
	logic [RB_W-1:0]  runb_inc;

	assign active   = ME < bc.n;
	assign in_rng   = (ME >= bc.lo) && (ME < bc.hi);
	assign run_inc  = tok_in.run + CNT_W'(1);
	assign runb_inc = tok_in.runb + RB_W'(BLOCK_BYTES);

	always_comb begin
		nxt = tok_in;
		if (tok_in.valid && active) begin
			unique case (bc.mode)
				MODE_ALLOC: begin
					if (!tok_in.done) begin
						if (free_q) begin
							nxt.run  = run_inc;
							nxt.runb = runb_inc;
							if (runb_inc >= RB_W'(bc.need_bytes)) begin
								nxt.done  = 1'b1;
								nxt.first = ME + CNT_W'(1) - run_inc;
							end
						end else begin
							nxt.run  = '0;
							nxt.runb = '0;
						end
					end
				end
				MODE_REL: begin
					if (in_rng && !free_q) begin
						nxt.run = run_inc;
					end
				end
				default: nxt = tok_in;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= 1'b1;
			tok_q  <= '0;
		end else begin
			tok_q <= nxt;
			if (bc.init) begin
				free_q <= 1'b1;
			end else if (bc.mark && in_rng) begin
				free_q <= 1'b0;
			end else if (tok_in.valid && active && bc.mode == MODE_REL && in_rng) begin
				free_q <= 1'b1;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

@@ rtl/core/bitmap_block_allocator_refcount_unit.sv @@
// Bitmap first-fit block allocator with reference counts: control, chain, count store.
// Allocate and a release that frees its span send one beat down the whole chain of
// MAX_BLOCKS cells, one cell per cycle. Retain and a release that keeps the span do one store
// read and a count write without the chain; query goes straight to the response.
// One item at a time; the response register lets the next request in while it waits.
// arst_n clears the pool to all free with managed_blocks 256; a configuration write re-initializes.
module bitmap_block_allocator_refcount_unit #(
	parameter int unsigned MAX_BLOCKS  = bba_pkg::DEF_MAX_BLOCKS,
	parameter int unsigned BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  bba_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output bba_pkg::rsp_t              rsp,
	input  logic                       cfg_we,
	input  logic [bba_pkg::CFG_W-1:0]  cfg_data
);
	import bba_pkg::*;

	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_GO, S_SCAN_WAIT, S_MARK, S_CHK, S_FREE_GO, S_FREE_WAIT, S_RESP
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] mb_q;
	logic [CNT_W-1:0] n_blocks;
	logic [CNT_W-1:0] n_cfg;
	logic [CNT_W-1:0] total_q;
	req_t             op_q;
	logic [1:0]       status_q;
	logic [7:0]       hnd_q;
	mode_t            mode_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [15:0]      ref_mem  [MAX_BLOCKS];
	logic [CNT_W-1:0] span_mem [MAX_BLOCKS];
	logic             vld_q    [MAX_BLOCKS];
	logic [15:0]      rd_ref_q;
	logic [CNT_W-1:0] rd_span_q;
	logic             rd_vld_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_addr;
	logic [15:0]      ref_wd;
	logic [CNT_W-1:0] span_wd;
	logic             vld_set;
	logic             vld_clr;

	bcast_t           bc;
	tok_t             inj;
	tok_t             chain [MAX_BLOCKS];
	tok_t             last_tok;

	logic             accept;
	logic [CNT_W-1:0] h_ext;
	logic [IDX_W-1:0] h_addr;
	logic [IDX_W-1:0] req_addr;
	logic             live;
	logic [15:0]      ref_dec;
	logic [CNT_W:0]   span_end;
	logic             rsp_free;
	logic [RB_W-1:0]  free_prod;

	assign n_blocks = (CNT_W'(mb_q) > MAXC) ? MAXC : CNT_W'(mb_q);
	assign n_cfg    = (CNT_W'(cfg_data) > MAXC) ? MAXC : CNT_W'(cfg_data);
	assign req_stall = (state_q != S_IDLE);
	assign accept   = req_valid && !req_stall;
	assign h_ext    = CNT_W'(op_q.handle);
	assign h_addr   = h_ext[IDX_W-1:0];
	assign req_addr = IDX_W'(req.handle);
	assign live     = (h_ext < n_blocks) && rd_vld_q && (rd_ref_q != 16'd0);
	assign ref_dec  = rd_ref_q - 16'd1;
	assign span_end = {1'b0, h_ext} + {1'b0, rd_span_q};
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign free_prod = RB_W'(total_q) * RB_W'(BLOCK_BYTES);

	always_comb begin
		bc.mode       = mode_q;
		bc.init       = cfg_we;
		bc.mark       = (state_q == S_MARK);
		bc.n          = n_blocks;
		bc.lo         = lo_q;
		bc.hi         = hi_q;
		bc.need_bytes = NEED_W'(op_q.alloc_size) + HEADER_BYTES;
		inj           = '0;
		inj.valid     = (state_q == S_SCAN_GO) || (state_q == S_FREE_GO);
	end

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		if (i == 0) begin : g_head
			bba_cell #(.IDX(i), .BLOCK_BYTES(BLOCK_BYTES)) u_cell (
				.clk(clk), .arst_n(arst_n), .bc(bc), .tok_in(inj), .tok_out(chain[i])
			);
		end else begin : g_body
			bba_cell #(.IDX(i), .BLOCK_BYTES(BLOCK_BYTES)) u_cell (
				.clk(clk), .arst_n(arst_n), .bc(bc), .tok_in(chain[i-1]), .tok_out(chain[i])
			);
		end
	end
	assign last_tok = chain[MAX_BLOCKS-1];

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = h_addr;
		ref_wd   = rd_ref_q;
		span_wd  = rd_span_q;
		vld_set  = 1'b0;
		vld_clr  = 1'b0;
		if (state_q == S_MARK) begin
			mem_we   = 1'b1;
			mem_addr = lo_q[IDX_W-1:0];
			ref_wd   = 16'd1;
			span_wd  = hi_q - lo_q;
			vld_set  = 1'b1;
		end else if (state_q == S_CHK && live) begin
			if (op_q.func == FUNC_RETAIN) begin
				mem_we = (rd_ref_q != REF_MAX);
				ref_wd = rd_ref_q + 16'd1;
			end else if (op_q.func == FUNC_RELEASE) begin
				mem_we  = 1'b1;
				ref_wd  = ref_dec;
				vld_clr = (ref_dec == 16'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ref_mem[mem_addr]  <= ref_wd;
			span_mem[mem_addr] <= span_wd;
		end
		if (accept) begin
			rd_ref_q  <= ref_mem[req_addr];
			rd_span_q <= span_mem[req_addr];
			rd_vld_q  <= vld_q[req_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (vld_set) begin
			vld_q[mem_addr] <= 1'b1;
		end else if (vld_clr) begin
			vld_q[mem_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mb_q        <= MB_RESET;
			total_q     <= (CNT_W'(MB_RESET) > MAXC) ? MAXC : CNT_W'(MB_RESET);
			mode_q      <= MODE_ALLOC;
			rsp_valid_q <= 1'b0;
			op_q        <= '0;
			status_q    <= ST_DONE;
			hnd_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			rsp_q       <= '0;
		end else begin
			if (state_q == S_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				mb_q    <= cfg_data;
				total_q <= n_cfg;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req;
						status_q <= ST_DONE;
						hnd_q    <= '0;
						unique case (req.func)
							FUNC_ALLOC: begin
								mode_q  <= MODE_ALLOC;
								state_q <= S_SCAN_GO;
							end
							FUNC_RETAIN, FUNC_RELEASE: state_q <= S_CHK;
							FUNC_QUERY:                state_q <= S_RESP;
							default:                   state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN_GO: state_q <= S_SCAN_WAIT;
				S_SCAN_WAIT: begin
					if (last_tok.valid) begin
						if (last_tok.done) begin
							lo_q    <= last_tok.first;
							hi_q    <= last_tok.first + last_tok.run;
							hnd_q   <= last_tok.first[7:0];
							state_q <= S_MARK;
						end else begin
							status_q <= ST_OOM;
							state_q  <= S_RESP;
						end
					end
				end
				S_MARK: begin
					total_q <= total_q - (hi_q - lo_q);
					state_q <= S_RESP;
				end
				S_CHK: begin
					if (op_q.func == FUNC_RELEASE && live && ref_dec == 16'd0) begin
						mode_q  <= MODE_REL;
						lo_q    <= h_ext;
						hi_q    <= (span_end > {1'b0, n_blocks}) ? n_blocks
							: span_end[CNT_W-1:0];
						state_q <= S_FREE_GO;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_FREE_GO: state_q <= S_FREE_WAIT;
				S_FREE_WAIT: begin
					if (last_tok.valid) begin
						total_q  <= total_q + last_tok.run;
						status_q <= ST_RELEASED;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.status       <= status_q;
						rsp_q.alloc_handle <= hnd_q;
						rsp_q.free_bytes   <= free_prod[13:0];
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("response raised outside response state");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= n_blocks)
		else $error("free block total exceeds pool size");
	a_chain_out: assert property (@(posedge clk) disable iff (!arst_n)
		last_tok.valid |-> (state_q == S_SCAN_WAIT || state_q == S_FREE_WAIT))
		else $error("chain beat arrived while not waiting");
`endif

endmodule
